/* rtl/shtok_pkg.sv */
// Shared constants, codes and types of the shell command tokenizer.
`timescale 1ns / 1ps
package shtok_pkg;

   localparam int TOKEN_SLOTS = 64;
   localparam int STORE_BYTES = 4096;
   localparam int MAX_RES     = 3;

   localparam int TOK_W   = $clog2(TOKEN_SLOTS);
   localparam int BYTES_W = $clog2(STORE_BYTES) + 1;
   localparam int CAP_W   = 13;
   localparam int OFF_W   = 12;
   localparam int CNT_W   = 2;

   localparam logic [7:0] CH_GT   = 8'h3E;
   localparam logic [7:0] CH_LT   = 8'h3C;
   localparam logic [7:0] CH_PIPE = 8'h7C;
   localparam logic [7:0] CH_DQ   = 8'h22;
   localparam logic [7:0] CH_SQ   = 8'h27;
   localparam logic [7:0] CH_BS   = 8'h5C;
   localparam logic [7:0] CH_SP   = 8'h20;
   localparam logic [7:0] CH_TAB  = 8'h09;
   localparam logic [7:0] CH_CR   = 8'h0D;

   typedef enum logic [1:0] {
      MODE_PLAIN  = 2'd0,
      MODE_SINGLE = 2'd1,
      MODE_DOUBLE = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      K_WORD_START = 3'd0,
      K_WORD_BYTE  = 3'd1,
      K_WORD_TERM  = 3'd2,
      K_OPERATOR   = 3'd3,
      K_DONE       = 3'd4,
      K_ERROR      = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      OP_PIPE   = 2'd0,
      OP_INPUT  = 2'd1,
      OP_OUTPUT = 2'd2,
      OP_APPEND = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ERR_STORAGE   = 2'd0,
      ERR_TOKENS    = 2'd1,
      ERR_QUOTE     = 2'd2,
      ERR_BACKSLASH = 2'd3
   } err_type;

   typedef struct packed {
      logic             last;
      logic [1:0]       err;
      logic [TOK_W-1:0] total;
      logic [1:0]       op;
      logic [TOK_W-1:0] tok;
      logic [OFF_W-1:0] offset;
      logic [7:0]       value;
      logic [2:0]       kind;
   } res_type;

   // Working copy of the line state while one item is evaluated.
   typedef struct packed {
      res_type [MAX_RES-1:0] res;
      logic [CNT_W-1:0]      n;
      logic                  failed;
      mode_type              mode;
      logic                  in_word;
      logic                  pend_gt;
      logic                  pend_bs;
      logic [BYTES_W-1:0]    bytes_used;
      logic [TOK_W-1:0]      tokens_used;
   } ctx_type;

endpackage

/* rtl/shell_command_tokenizer.sv */
// Shell command line tokenizer: splits a byte stream into words and redirection operators.
`timescale 1ns / 1ps
// The block takes a command line one byte per item on the req channel and an end
// marker item (req_tlast high, data ignored) after the last byte. It reports each word
// as a word start event, its bytes and a zero terminator, each with its offset in word
// storage, and reports the operators |, <, > and >> with their token slot. Single
// quotes make their content literal; inside double quotes a backslash escapes only a
// double quote or a backslash; an unquoted backslash escapes any next byte. A '>' is
// held until the next item shows whether it is an append. The end marker gives a done
// event with the token count, or an error. Any error (storage full, token limit,
// unclosed quote, trailing backslash) ends the line: later bytes are dropped silently
// up to and including the end marker. The csr channel sets the storage capacity in
// bytes; write it only while the block is idle. Each item is decoded in the cycle it
// is accepted and gives zero to three result items, which are loaded into a three-entry
// output buffer and leave one per cycle while the receiver is ready. An item can be
// accepted every cycle as long as at most one result waits (and it is taken in that
// cycle); an item that produces several results therefore holds the input until all
// but the last have been drained from the buffer by the single result port.
module shell_command_tokenizer
   import shtok_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] char_byte
   input  logic             req_tlast,   // is_end
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // [7:0] byte_value, [19:8] storage_offset, [25:20] token_index,
   // [27:26] operator_code, [33:28] token_total, [35:34] error_code, [39:36] zero
   output logic [39:0]      rsp_tdata,
   output logic [2:0]       rsp_tuser,   // [2:0] event_kind
   output logic             rsp_tlast,   // last_of_run
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_data     // storage_capacity
);

   // Line state.
   mode_type             mode_ff;
   logic                 in_word_ff;
   logic                 pend_gt_ff;
   logic                 pend_bs_ff;
   logic [BYTES_W-1:0]   bytes_used_ff;
   logic [TOK_W-1:0]     tokens_used_ff;
   logic                 discarding_ff;
   logic                 discarding_in;
   logic [CAP_W-1:0]     capacity_ff;

   // Output buffer, entry 0 is presented on the rsp channel.
   res_type [MAX_RES-1:0] buf_ff;
   logic [CNT_W-1:0]      count_ff;

   ctx_type              ctx;
   logic                 skip;
   logic [BYTES_W-1:0]   cap_v;
   logic [7:0]           c;
   logic                 accept;
   logic                 pop;

   function automatic res_type mk(kind_type k, logic [7:0] v, logic [BYTES_W-1:0] off,
                                  logic [TOK_W-1:0] tok, op_type op,
                                  logic [TOK_W-1:0] tot, err_type err);
      res_type r;
      r.kind   = k;
      r.value  = v;
      r.offset = off[OFF_W-1:0];
      r.tok    = tok;
      r.op     = op;
      r.total  = tot;
      r.err    = err;
      r.last   = 1'b0;
      return r;
   endfunction

   function automatic ctx_type f_put(ctx_type x, res_type r);
      ctx_type y;
      y = x;
      if (y.n != CNT_W'(MAX_RES)) begin
         y.res[y.n] = r;
         y.n        = y.n + 1'b1;
      end
      return y;
   endfunction

   function automatic ctx_type f_fail(ctx_type x, err_type err);
      ctx_type y;
      y = f_put(x, mk(K_ERROR, 8'd0, '0, '0, OP_PIPE, '0, err));
      y.failed = 1'b1;
      return y;
   endfunction

   function automatic ctx_type f_store(ctx_type x, logic [7:0] b, logic [BYTES_W-1:0] cp);
      ctx_type y;
      y = x;
      if (!y.failed) begin
         if (y.bytes_used >= cp) begin
            y = f_fail(y, ERR_STORAGE);
         end else begin
            y = f_put(y, mk(K_WORD_BYTE, b, y.bytes_used, '0, OP_PIPE, '0, ERR_STORAGE));
            y.bytes_used = y.bytes_used + 1'b1;
         end
      end
      return y;
   endfunction

   function automatic ctx_type f_room(ctx_type x);
      ctx_type y;
      y = x;
      if (!y.failed && y.tokens_used >= TOK_W'(TOKEN_SLOTS - 1)) begin
         y = f_fail(y, ERR_TOKENS);
      end
      return y;
   endfunction

   function automatic ctx_type f_open(ctx_type x, logic [BYTES_W-1:0] cp);
      ctx_type y;
      y = x;
      if (!y.failed && !y.in_word) begin
         if (y.bytes_used >= cp) begin
            y = f_fail(y, ERR_STORAGE);
         end else begin
            y = f_room(y);
            if (!y.failed) begin
               y = f_put(y, mk(K_WORD_START, 8'd0, y.bytes_used, y.tokens_used,
                               OP_PIPE, '0, ERR_STORAGE));
               y.tokens_used = y.tokens_used + 1'b1;
               y.in_word     = 1'b1;
            end
         end
      end
      return y;
   endfunction

   function automatic ctx_type f_close(ctx_type x, logic [BYTES_W-1:0] cp);
      ctx_type y;
      y = x;
      if (!y.failed && y.in_word) begin
         if (y.bytes_used >= cp) begin
            y = f_fail(y, ERR_STORAGE);
         end else begin
            y = f_put(y, mk(K_WORD_TERM, 8'd0, y.bytes_used, '0, OP_PIPE, '0, ERR_STORAGE));
            y.bytes_used = y.bytes_used + 1'b1;
            y.in_word    = 1'b0;
         end
      end
      return y;
   endfunction

   function automatic ctx_type f_op(ctx_type x, op_type code);
      ctx_type y;
      y = f_put(x, mk(K_OPERATOR, 8'd0, '0, x.tokens_used, code, '0, ERR_STORAGE));
      y.tokens_used = y.tokens_used + 1'b1;
      return y;
   endfunction

   function automatic logic is_blank(logic [7:0] b);
      return (b == CH_SP) || (b >= CH_TAB && b <= CH_CR);
   endfunction

   assign c      = req_tdata;
   assign accept = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;
   assign cap_v  = (capacity_ff > CAP_W'(STORE_BYTES)) ? BYTES_W'(STORE_BYTES)
                                                       : BYTES_W'(capacity_ff);

   // Whole decision for one item: the sequence of checks follows the tokenizer rules,
   // each step only a compare and an increment on narrow counters.
   always_comb begin
      ctx             = '0;
      ctx.mode        = mode_ff;
      ctx.in_word     = in_word_ff;
      ctx.pend_gt     = pend_gt_ff;
      ctx.pend_bs     = pend_bs_ff;
      ctx.bytes_used  = bytes_used_ff;
      ctx.tokens_used = tokens_used_ff;
      discarding_in   = discarding_ff;
      skip            = 1'b0;

      if (req_tlast) begin
         if (!discarding_ff) begin
            if (ctx.pend_bs) begin
               ctx = f_fail(ctx, ERR_BACKSLASH);
            end else begin
               if (ctx.pend_gt) begin
                  ctx = f_op(ctx, OP_OUTPUT);
               end
               if (ctx.mode != MODE_PLAIN) begin
                  ctx = f_fail(ctx, ERR_QUOTE);
               end else begin
                  ctx = f_close(ctx, cap_v);
                  if (!ctx.failed) begin
                     ctx = f_put(ctx, mk(K_DONE, 8'd0, '0, '0, OP_PIPE, ctx.tokens_used,
                                         ERR_STORAGE));
                  end
               end
            end
         end
         discarding_in = 1'b0;
      end else if (!discarding_ff) begin
         // A held '>' goes out first, or merges with this one into an append.
         if (ctx.pend_gt) begin
            ctx.pend_gt = 1'b0;
            if (c == CH_GT) begin
               ctx  = f_op(ctx, OP_APPEND);
               skip = 1'b1;
            end else begin
               ctx = f_op(ctx, OP_OUTPUT);
            end
         end
         if (!skip) begin
            case (ctx.mode)
               MODE_SINGLE: begin
                  if (c == CH_SQ) begin
                     ctx.mode = MODE_PLAIN;
                  end else begin
                     ctx = f_store(ctx, c, cap_v);
                  end
               end
               MODE_DOUBLE: begin
                  if (ctx.pend_bs) begin
                     ctx.pend_bs = 1'b0;
                     if (c == CH_DQ || c == CH_BS) begin
                        ctx  = f_store(ctx, c, cap_v);
                        skip = 1'b1;
                     end else begin
                        // The backslash itself is kept as a byte of the word.
                        ctx = f_store(ctx, CH_BS, cap_v);
                     end
                  end
                  if (!skip && !ctx.failed) begin
                     if (c == CH_DQ) begin
                        ctx.mode = MODE_PLAIN;
                     end else if (c == CH_BS) begin
                        ctx.pend_bs = 1'b1;
                     end else begin
                        ctx = f_store(ctx, c, cap_v);
                     end
                  end
               end
               default: begin
                  if (ctx.pend_bs) begin
                     ctx.pend_bs = 1'b0;
                     ctx = f_open(ctx, cap_v);
                     ctx = f_store(ctx, c, cap_v);
                  end else if (c == CH_BS) begin
                     ctx.pend_bs = 1'b1;
                  end else if (is_blank(c)) begin
                     ctx = f_close(ctx, cap_v);
                  end else if (c == CH_SQ || c == CH_DQ) begin
                     ctx = f_open(ctx, cap_v);
                     if (!ctx.failed) begin
                        ctx.mode = (c == CH_SQ) ? MODE_SINGLE : MODE_DOUBLE;
                     end
                  end else if (c == CH_PIPE || c == CH_LT || c == CH_GT) begin
                     ctx = f_close(ctx, cap_v);
                     ctx = f_room(ctx);
                     if (!ctx.failed) begin
                        if (c == CH_GT) begin
                           ctx.pend_gt = 1'b1;
                        end else begin
                           ctx = f_op(ctx, (c == CH_PIPE) ? OP_PIPE : OP_INPUT);
                        end
                     end
                  end else begin
                     ctx = f_open(ctx, cap_v);
                     ctx = f_store(ctx, c, cap_v);
                  end
               end
            endcase
         end
         if (ctx.failed) begin
            discarding_in = 1'b1;
         end
      end

      // An error, an end marker or a done event leaves a fresh line behind.
      if (req_tlast || ctx.failed) begin
         ctx.mode        = MODE_PLAIN;
         ctx.in_word     = 1'b0;
         ctx.pend_gt     = 1'b0;
         ctx.pend_bs     = 1'b0;
         ctx.bytes_used  = '0;
         ctx.tokens_used = '0;
      end

      if (ctx.n != '0) begin
         ctx.res[ctx.n - 1'b1].last = 1'b1;
      end
   end

   // The input is free when the buffer is empty or its single entry leaves now.
   assign req_tready = (count_ff == '0) || (count_ff == CNT_W'(1) && rsp_tready);
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tuser  = buf_ff[0].kind;
   assign rsp_tlast  = buf_ff[0].last;
   assign rsp_tdata  = {4'd0, buf_ff[0].err, buf_ff[0].total, buf_ff[0].op,
                        buf_ff[0].tok, buf_ff[0].offset, buf_ff[0].value};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_PLAIN;
         in_word_ff     <= 1'b0;
         pend_gt_ff     <= 1'b0;
         pend_bs_ff     <= 1'b0;
         bytes_used_ff  <= '0;
         tokens_used_ff <= '0;
         discarding_ff  <= 1'b0;
         capacity_ff    <= CAP_W'(STORE_BYTES);
         count_ff       <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_data;
         end
         if (accept) begin
            mode_ff        <= ctx.mode;
            in_word_ff     <= ctx.in_word;
            pend_gt_ff     <= ctx.pend_gt;
            pend_bs_ff     <= ctx.pend_bs;
            bytes_used_ff  <= ctx.bytes_used;
            tokens_used_ff <= ctx.tokens_used;
            discarding_ff  <= discarding_in;
            count_ff       <= ctx.n;
         end else if (pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         buf_ff <= ctx.res;
      end else if (pop) begin
         buf_ff[0] <= buf_ff[1];
         buf_ff[1] <= buf_ff[2];
      end
   end

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the shell command tokenizer: stream stimulus, prediction and checks.
`timescale 1ns / 1ps

// The testbench feeds command lines into the tokenizer one byte item at a time, each line
// closed by an end marker item. A clocked driver takes items from a queue that the main
// initial block fills. A clocked monitor watches the three channels at every rising edge.
//
// For every byte or end marker accepted on the req channel, the monitor runs a behavioral
// model of the tokenizer. The model keeps its own quote mode, word and pending-operator
// flags, storage and token counters, and storage capacity. It appends the events that it
// predicts to a queue. Every rsp item is checked field by field against the oldest entry
// of that queue.
//
// The run starts with a short directed part:
//   - zero and all-ones bytes inside a word;
//   - every operator, including a '>' still held at the end marker;
//   - single and double quotes;
//   - the escapes inside double quotes;
//   - an unquoted escape of a space;
//   - the two end-of-line errors.
// Eight random phases follow, each with its own storage capacity. The capacity is written
// only while nothing is in flight. The capacities include zero, a few bytes, the full store
// and the largest value the register can hold. The first phase also sends a line with
// a token count around the token limit.
module testbench;
   import shtok_pkg::*;

   localparam int CLOCK_PERIOD     = 10;
   localparam int RESET_CYCLES     = 7;
   localparam int SETTLE_CYCLES    = 8;
   localparam int PHASE_ITEMS      = 6;
   localparam int NUM_PHASES       = 8;
   localparam int TIMEOUT_NS       = 2_000_000;

   // One byte of a command line, or the end marker when last is set.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } line_item_type;

   // Ways of leaving a line unfinished right before its end marker.
   typedef enum int {
      UNF_SQ,
      UNF_DQ,
      UNF_BS,
      UNF_DQ_BS
   } unfinished_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata  = 8'h00;
   logic             req_tlast  = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [39:0]      rsp_tdata;
   logic [2:0]       rsp_tuser;
   logic             rsp_tlast;
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_data   = '0;

   shell_command_tokenizer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] char_byte
      .req_tlast  (req_tlast),   // is_end
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // [7:0] byte_value, [19:8] storage_offset, [25:20] token_index,
      // [27:26] operator_code, [33:28] token_total, [35:34] error_code, [39:36] zero
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),   // [2:0] event_kind
      .rsp_tlast  (rsp_tlast),   // last_of_run
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)     // storage_capacity
   );

   // Stimulus queue and handshake bookkeeping.
   line_item_type pending_chars [$];
   line_item_type next_char;
   logic       req_taken = 1'b0;
   logic       csr_taken = 1'b0;
   int         items_queued   = 0;
   int         items_accepted = 0;
   int         results_seen   = 0;
   int         error_count    = 0;
   int         sender_idle_pct   = 22;
   int         receiver_idle_pct = 66;

   // Bytes used for the content of well-formed words.
   string word_chars = "abcdefghijklmnopqrstuvwxyz0123456789._-/=";

   // Behavioral model of the tokenizer, with its own line state.
   int       line_capacity = STORE_BYTES;
   mode_type quote_mode    = MODE_PLAIN;
   logic     in_word       = 1'b0;
   logic     gt_held       = 1'b0;
   logic     bs_held       = 1'b0;
   logic     dropping_line = 1'b0;
   logic     item_failed   = 1'b0;
   int       bytes_used    = 0;
   int       tokens_used   = 0;
   int       item_results  = 0;
   res_type  item_events [MAX_RES];
   res_type  expected_events [$];

   function automatic void clear_line_state();
      quote_mode  = MODE_PLAIN;
      in_word     = 1'b0;
      gt_held     = 1'b0;
      bs_held     = 1'b0;
      bytes_used  = 0;
      tokens_used = 0;
   endfunction

   function automatic void reset_tokenizer_model();
      line_capacity = STORE_BYTES;
      clear_line_state();
      dropping_line = 1'b0;
   endfunction

   // Capacities above the physical store behave like the full store.
   function automatic int usable_bytes();
      return (line_capacity > STORE_BYTES) ? STORE_BYTES : line_capacity;
   endfunction

   // Records one event of the current item. An item never gives more than three events.
   function automatic void emit(kind_type kind, logic [7:0] value, int offset, int tok,
                                logic [1:0] op, int total, logic [1:0] err);
      res_type r;
      if (item_results >= MAX_RES) begin
         return;
      end
      r.kind   = kind;
      r.value  = value;
      r.offset = offset[OFF_W-1:0];
      r.tok    = tok[TOK_W-1:0];
      r.op     = op;
      r.total  = total[TOK_W-1:0];
      r.err    = err;
      r.last   = 1'b0;
      item_events[item_results] = r;
      item_results++;
   endfunction

   function automatic void raise_error(err_type code);
      emit(K_ERROR, 8'h00, 0, 0, 2'b00, 0, code);
      item_failed = 1'b1;
   endfunction

   function automatic bit store_text_byte(logic [7:0] c);
      if (bytes_used >= usable_bytes()) begin
         raise_error(ERR_STORAGE);
         return 1'b0;
      end
      emit(K_WORD_BYTE, c, bytes_used, 0, 2'b00, 0, 2'b00);
      bytes_used++;
      return 1'b1;
   endfunction

   // The last token slot stays unused, so a line holds one token fewer than there are slots.
   function automatic bit token_free();
      if (tokens_used >= TOKEN_SLOTS - 1) begin
         raise_error(ERR_TOKENS);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic bit enter_word();
      if (in_word) begin
         return 1'b1;
      end
      if (bytes_used >= usable_bytes()) begin
         raise_error(ERR_STORAGE);
         return 1'b0;
      end
      if (!token_free()) begin
         return 1'b0;
      end
      emit(K_WORD_START, 8'h00, bytes_used, tokens_used, 2'b00, 0, 2'b00);
      tokens_used++;
      in_word = 1'b1;
      return 1'b1;
   endfunction

   // The zero terminator takes a storage byte too, so it can overflow the store.
   function automatic bit end_word();
      if (!in_word) begin
         return 1'b1;
      end
      if (bytes_used >= usable_bytes()) begin
         raise_error(ERR_STORAGE);
         return 1'b0;
      end
      emit(K_WORD_TERM, 8'h00, bytes_used, 0, 2'b00, 0, 2'b00);
      bytes_used++;
      in_word = 1'b0;
      return 1'b1;
   endfunction

   function automatic void push_operator(op_type code);
      emit(K_OPERATOR, 8'h00, 0, tokens_used, code, 0, 2'b00);
      tokens_used++;
   endfunction

   function automatic bit is_blank(logic [7:0] c);
      return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic void plain_char(logic [7:0] c);
      if (c == CH_BS) begin
         bs_held = 1'b1;
      end else if (is_blank(c)) begin
         void'(end_word());
      end else if (c == CH_SQ || c == CH_DQ) begin
         if (enter_word()) begin
            quote_mode = (c == CH_SQ) ? MODE_SINGLE : MODE_DOUBLE;
         end
      end else if (c == CH_PIPE || c == CH_LT || c == CH_GT) begin
         // The room for the token is checked now, even for a '>' that is held back.
         if (!end_word() || !token_free()) begin
            return;
         end
         if (c == CH_GT) begin
            gt_held = 1'b1;
         end else begin
            push_operator((c == CH_PIPE) ? OP_PIPE : OP_INPUT);
         end
      end else begin
         if (enter_word()) begin
            void'(store_text_byte(c));
         end
      end
   endfunction

   function automatic void take_char(logic [7:0] c);
      // A held '>' goes out first, or merges with this one into an append.
      if (gt_held) begin
         gt_held = 1'b0;
         if (c == CH_GT) begin
            push_operator(OP_APPEND);
            return;
         end
         push_operator(OP_OUTPUT);
      end
      if (quote_mode == MODE_SINGLE) begin
         if (c == CH_SQ) begin
            quote_mode = MODE_PLAIN;
         end else begin
            void'(store_text_byte(c));
         end
      end else if (quote_mode == MODE_DOUBLE) begin
         // Inside double quotes a backslash that escapes nothing is kept as a byte.
         if (bs_held) begin
            bs_held = 1'b0;
            if (c == CH_DQ || c == CH_BS) begin
               void'(store_text_byte(c));
               return;
            end
            if (!store_text_byte(CH_BS)) begin
               return;
            end
         end
         if (c == CH_DQ) begin
            quote_mode = MODE_PLAIN;
         end else if (c == CH_BS) begin
            bs_held = 1'b1;
         end else begin
            void'(store_text_byte(c));
         end
      end else begin
         if (bs_held) begin
            bs_held = 1'b0;
            if (enter_word()) begin
               void'(store_text_byte(c));
            end
            return;
         end
         plain_char(c);
      end
   endfunction

   function automatic void take_end_marker();
      if (bs_held) begin
         raise_error(ERR_BACKSLASH);
         return;
      end
      if (gt_held) begin
         gt_held = 1'b0;
         push_operator(OP_OUTPUT);
      end
      if (quote_mode != MODE_PLAIN) begin
         raise_error(ERR_QUOTE);
         return;
      end
      if (!end_word()) begin
         return;
      end
      emit(K_DONE, 8'h00, 0, 0, 2'b00, tokens_used, 2'b00);
   endfunction

   // Works out the events of one accepted item and queues them, marking the last one.
   function automatic void tokenize_item(logic [7:0] c, logic is_end);
      res_type r;
      item_results = 0;
      item_failed  = 1'b0;
      if (is_end) begin
         if (!dropping_line) begin
            take_end_marker();
         end
         clear_line_state();
         dropping_line = 1'b0;
      end else if (!dropping_line) begin
         // After an error on a byte, everything up to the end marker is dropped.
         take_char(c);
         if (item_failed) begin
            clear_line_state();
            dropping_line = 1'b1;
         end
      end
      for (int i = 0; i < item_results; i++) begin
         r      = item_events[i];
         r.last = (i == item_results - 1);
         expected_events.push_back(r);
      end
   endfunction

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(string msg);
      error_count++;
      $display("ERROR at %0t ns: %s", $time, msg);
   endtask

   task automatic check_field(string name, logic [39:0] got, logic [39:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                   results_seen, name, got, want));
      end
   endtask

   task automatic check_result();
      res_type want;
      results_seen++;
      if (expected_events.size() == 0) begin
         report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
         return;
      end
      want = expected_events.pop_front();
      check_field("event_kind", 40'(rsp_tuser), 40'(want.kind));
      check_field("byte_value", 40'(rsp_tdata[7:0]), 40'(want.value));
      check_field("storage_offset", 40'(rsp_tdata[19:8]), 40'(want.offset));
      check_field("token_index", 40'(rsp_tdata[25:20]), 40'(want.tok));
      check_field("operator_code", 40'(rsp_tdata[27:26]), 40'(want.op));
      check_field("token_total", 40'(rsp_tdata[33:28]), 40'(want.total));
      check_field("error_code", 40'(rsp_tdata[35:34]), 40'(want.err));
      check_field("padding", 40'(rsp_tdata[39:36]), 40'(0));
      check_field("last_of_run", 40'(rsp_tlast), 40'(want.last));
   endtask

   // Free-running clock.
   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Monitor: all three channels are sampled at the rising edge. Predictions for an item
   // accepted at this edge are queued before the result check, so the order holds even if
   // the block could answer in the same cycle.
   always @(posedge clock) begin
      if (reset) begin
         reset_tokenizer_model();
         req_taken <= 1'b0;
         csr_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         csr_taken <= csr_valid && csr_ready;
         if (csr_valid && csr_ready) begin
            line_capacity = int'(csr_data);
         end
         if (req_tvalid && req_tready) begin
            tokenize_item(req_tdata, req_tlast);
            items_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            check_result();
         end
      end
   end

   // Driver: it moves on at the falling edge after an item has been taken, or while idle.
   // Gaps on the sender side and stalls on the receiver side follow the current percentages.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            if (pending_chars.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               next_char = pending_chars.pop_front();
               req_tdata  <= next_char.data;
               req_tlast  <= next_char.last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   task automatic queue_char(logic [7:0] c);
      line_item_type it;
      it.data = c;
      it.last = 1'b0;
      pending_chars.push_back(it);
      items_queued++;
   endtask

   // The byte lane of an end marker carries random bits, which the block has to ignore.
   task automatic queue_end();
      line_item_type it;
      it.data = 8'($urandom_range(0, 255));
      it.last = 1'b1;
      pending_chars.push_back(it);
      items_queued++;
   endtask

   task automatic queue_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         queue_char(s[i]);
      end
   endtask

   function automatic logic [7:0] plain_letter();
      return word_chars[$urandom_range(0, word_chars.len() - 1)];
   endfunction

   // Mostly spaces, otherwise any of tab, newline, vertical tab, form feed and return.
   task automatic queue_blank();
      if ($urandom_range(0, 2) == 0) begin
         queue_char(CH_TAB + 8'($urandom_range(0, 4)));
      end else begin
         queue_char(CH_SP);
      end
   endtask

   task automatic queue_operator();
      case ($urandom_range(0, 3))
         0: queue_char(CH_PIPE);
         1: queue_char(CH_LT);
         2: queue_char(CH_GT);
         default: begin
            queue_char(CH_GT);
            queue_char(CH_GT);
         end
      endcase
   endtask

   // A word is built from bare text, quoted sections and escapes. Quoted content is any byte but
   // its closing quote, unquoted escaped bytes any value: every data bit toggles in real words.
   task automatic queue_word();
      int         parts;
      int         len;
      logic [7:0] c;
      parts = $urandom_range(1, 3);
      for (int k = 0; k < parts; k++) begin
         case ($urandom_range(0, 4))
            0, 1: begin
               len = $urandom_range(1, 4);
               for (int j = 0; j < len; j++) begin
                  queue_char(plain_letter());
               end
            end
            2: begin
               queue_char(CH_SQ);
               len = $urandom_range(0, 3);
               for (int j = 0; j < len; j++) begin
                  do c = 8'($urandom_range(0, 255)); while (c == CH_SQ);
                  queue_char(c);
               end
               queue_char(CH_SQ);
            end
            3: begin
               queue_char(CH_DQ);
               len = $urandom_range(0, 3);
               for (int j = 0; j < len; j++) begin
                  if ($urandom_range(0, 2) == 0) begin
                     // An escape that is consumed, or a backslash that stays in the word.
                     queue_char(CH_BS);
                     case ($urandom_range(0, 2))
                        0: queue_char(CH_DQ);
                        1: queue_char(CH_BS);
                        default: queue_char(plain_letter());
                     endcase
                  end else begin
                     do c = 8'($urandom_range(0, 255)); while (c == CH_DQ || c == CH_BS);
                     queue_char(c);
                  end
               end
               queue_char(CH_DQ);
            end
            default: begin
               queue_char(CH_BS);
               queue_char(8'($urandom_range(0, 255)));
            end
         endcase
      end
   endtask

   // Words and operators. The separator is sometimes left out, which joins words or
   // glues an operator to its neighbor.
   task automatic queue_tokens(int count);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 3) == 0) begin
            queue_operator();
         end else begin
            queue_word();
         end
         if ($urandom_range(0, 3) != 0) begin
            queue_blank();
         end
      end
   endtask

   task automatic queue_unfinished_tail();
      case (unfinished_type'($urandom_range(0, 3)))
         UNF_SQ: begin
            queue_char(CH_SQ);
            queue_char(plain_letter());
         end
         UNF_DQ: begin
            queue_char(CH_DQ);
            queue_char(plain_letter());
         end
         UNF_BS: begin
            queue_char(CH_BS);
         end
         default: begin
            queue_char(CH_DQ);
            queue_char(plain_letter());
            queue_char(CH_BS);
         end
      endcase
   endtask

   // Most lines are well formed. The rest end inside a quote or after a backslash, or
   // are raw bytes.
   task automatic queue_random_line();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         queue_tokens($urandom_range(0, 6));
      end else if (pick < 80) begin
         queue_tokens($urandom_range(0, 3));
         queue_unfinished_tail();
      end else begin
         repeat ($urandom_range(1, 10)) queue_char(8'($urandom_range(0, 255)));
      end
      queue_end();
   endtask

   // A line with a token count around the limit: it either just fits, or fails on a token
   // and drops the rest of the line. Most tokens are pipes to keep the line short.
   task automatic queue_flood_line();
      int count;
      count = $urandom_range(TOKEN_SLOTS - 3, TOKEN_SLOTS + 2);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 3) != 0) begin
            queue_char(CH_PIPE);
         end else begin
            queue_char(plain_letter());
            queue_blank();
         end
      end
      queue_end();
   endtask

   // Waits until every queued item has been accepted and every predicted event has come.
   // A further settling wait then lets an item without results finish inside the block.
   task automatic wait_for_idle();
      do @(negedge clock); while (items_accepted != items_queued || expected_events.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_capacity(int value);
      csr_data  <= CAP_W'(value);
      csr_valid <= 1'b1;
      do @(negedge clock); while (!csr_taken);
      csr_valid <= 1'b0;
   endtask

   // Main sequence: reset, directed lines, then the random phases.
   initial begin
      int caps [NUM_PHASES];
      int phase_start;
      // Phase 1 has a capacity of zero, so every word fails at once. The largest
      // register value has to act like the full store.
      caps    = '{8191, 0, 1, 6, 4096, 0, 13, 4096};
      caps[5] = $urandom_range(2, 60);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Zero and all-ones bytes are ordinary word bytes. A tab ends the word. A '>' is
      // still held when the end marker comes, and is then sent as an output redirect.
      queue_char(8'h00);
      queue_char(8'hFF);
      queue_char(CH_TAB);
      queue_char(CH_PIPE);
      queue_char(CH_GT);
      queue_end();
      // A single-quoted part, then double quotes with an escaped quote, an escaped
      // backslash and a kept backslash, then an escaped space. Then append and input.
      queue_text("'a'\"\\\"\\\\\\q\"\\ >><");
      queue_end();
      // A backslash inside open double quotes at the end marker.
      queue_char(CH_DQ);
      queue_char(CH_BS);
      queue_end();
      // A single quote that is never closed.
      queue_char(CH_SQ);
      queue_end();

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_for_idle();
         if (p < 3) begin
            sender_idle_pct   = 22;
            receiver_idle_pct = 66;
         end else if (p < 6) begin
            sender_idle_pct   = 66;
            receiver_idle_pct = 22;
         end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         write_capacity(caps[p]);
         if (p == 0) begin
            queue_flood_line();
         end
         phase_start = items_queued;
         while (items_queued - phase_start < PHASE_ITEMS) begin
            queue_random_line();
         end
      end

      wait_for_idle();
      repeat (2 * SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog: a hung handshake or a missing result ends the run here.
   initial begin
      #(TIMEOUT_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
